### rtl/tape_pulse_generator_assert.svh
// Assertion macros used by the tape pulse generator port-level checker.
`ifndef TAPE_PULSE_GENERATOR_ASSERT_SVH
`define TAPE_PULSE_GENERATOR_ASSERT_SVH

// Implication checked while out of reset.
`define TPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked while out of reset.
`define TPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every edge, reset included.
`define TPG_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tpg_pkg.sv
// Package with types, codes and reset constants of the tape pulse generator.
`timescale 1ns / 1ps
package tpg_pkg;

    localparam int CYCLE_BITS_DEF = 48;
    localparam int LEN_W          = 16;
    localparam int GAP_W          = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    localparam logic [LEN_W-1:0] PILOT_LEN_RST   = 16'd2168;
    localparam logic [LEN_W-1:0] SYNC1_LEN_RST   = 16'd667;
    localparam logic [LEN_W-1:0] SYNC2_LEN_RST   = 16'd735;
    localparam logic [LEN_W-1:0] ZERO_LEN_RST    = 16'd855;
    localparam logic [LEN_W-1:0] ONE_LEN_RST     = 16'd1710;
    localparam logic [GAP_W-1:0] GAP_LEN_RST     = 24'd3500000;
    localparam logic [LEN_W-1:0] HDR_PILOT_RST   = 16'd8063;
    localparam logic [LEN_W-1:0] DATA_PILOT_RST  = 16'd3223;
    localparam logic [7:0]       BIT_MASK_INIT   = 8'h80;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_SUPPLY = 2'd2,
        CMD_TOGGLE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PILOT = 3'd1,
        PH_SYNC1 = 3'd2,
        PH_SYNC2 = 3'd3,
        PH_DATA  = 3'd4,
        PH_GAP   = 3'd5
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PILOT_LEN  = 3'd0,
        CFG_SYNC1_LEN  = 3'd1,
        CFG_SYNC2_LEN  = 3'd2,
        CFG_ZERO_LEN   = 3'd3,
        CFG_ONE_LEN    = 3'd4,
        CFG_GAP_LEN    = 3'd5,
        CFG_HDR_PILOT  = 3'd6,
        CFG_DATA_PILOT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]       command;
        logic [LEN_W-1:0] block_size;
        logic             header_block;
        logic [7:0]       data_byte;
    } t_item;

    typedef struct packed {
        logic       ear_bit;
        logic [2:0] phase;
        logic       need_byte;
        logic       request_block;
        logic       underrun;
    } t_result;

endpackage

### rtl/tpg_in_if.sv
// Command channel interface: valid/ready with one command transaction.
`timescale 1ns / 1ps
interface tpg_in_if
    import tpg_pkg::*;
#(
    parameter int CYCLE_BITS = CYCLE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            command;
    logic [CYCLE_BITS-1:0] cycle_now;
    logic [LEN_W-1:0]      block_size;
    logic                  header_block;
    logic [7:0]            data_byte;

    modport source (output valid, command, cycle_now, block_size, header_block, data_byte,
                    input ready);
    modport sink   (input valid, command, cycle_now, block_size, header_block, data_byte,
                    output ready);
endinterface

### rtl/tpg_out_if.sv
// Result channel interface: valid/ready with one result transaction.
`timescale 1ns / 1ps
interface tpg_out_if;
    logic       valid;
    logic       ready;
    logic       ear_bit;
    logic [2:0] phase;
    logic       need_byte;
    logic       request_block;
    logic       underrun;

    modport source (output valid, ear_bit, phase, need_byte, request_block, underrun,
                    input ready);
    modport sink   (input valid, ear_bit, phase, need_byte, request_block, underrun,
                    output ready);
endinterface

### rtl/tape_pulse_generator.sv
// A command transaction's result is registered: input register then state/result register.
// Throughput: one transaction per cycle while the result sink takes each result.
// With the sink stalled the input register takes one more transaction, then ready drops.
// Reset (i_rst_n low, synchronous): configuration returns to defaults,
// the block goes idle, both registers empty and command ready is held low.
`timescale 1ns / 1ps
module tape_pulse_generator
    import tpg_pkg::*;
#(
    parameter int CYCLE_BITS = CYCLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tpg_in_if.sink                i_cmd_chan,
    tpg_out_if.source             o_res_chan
);
    t_item                 in_item, s1_item;
    logic [CYCLE_BITS-1:0] s1_cycle;
    logic                  s1_valid, s1_take;
    t_result               res;
    logic                  res_valid;

    assign in_item.command      = i_cmd_chan.command;
    assign in_item.block_size   = i_cmd_chan.block_size;
    assign in_item.header_block = i_cmd_chan.header_block;
    assign in_item.data_byte    = i_cmd_chan.data_byte;

    tpg_in_reg #(.CYCLE_BITS(CYCLE_BITS)) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd_chan.valid),
        .i_item  (in_item),
        .i_cycle (i_cmd_chan.cycle_now),
        .o_ready (i_cmd_chan.ready),
        .i_take  (s1_take),
        .o_valid (s1_valid),
        .o_item  (s1_item),
        .o_cycle (s1_cycle)
    );

    tpg_engine #(.CYCLE_BITS(CYCLE_BITS)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s1_valid),
        .i_item      (s1_item),
        .i_cycle     (s1_cycle),
        .o_take      (s1_take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (o_res_chan.ready)
    );

    assign o_res_chan.valid         = res_valid;
    assign o_res_chan.ear_bit       = res.ear_bit;
    assign o_res_chan.phase         = res.phase;
    assign o_res_chan.need_byte     = res.need_byte;
    assign o_res_chan.request_block = res.request_block;
    assign o_res_chan.underrun      = res.underrun;
endmodule

### rtl/tpg_in_reg.sv
// Input register stage holding one command transaction.
`timescale 1ns / 1ps
module tpg_in_reg
    import tpg_pkg::*;
#(
    parameter int CYCLE_BITS = CYCLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_item                 i_item,
    input  logic [CYCLE_BITS-1:0] i_cycle,
    output logic                  o_ready,
    input  logic                  i_take,
    output logic                  o_valid,
    output t_item                 o_item,
    output logic [CYCLE_BITS-1:0] o_cycle
);
    logic                  r_valid;
    t_item                 r_item;
    logic [CYCLE_BITS-1:0] r_cycle;

    assign o_ready = i_rst_n && (!r_valid || i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_item  <= i_item;
            r_cycle <= i_cycle;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_cycle = r_cycle;
endmodule

### rtl/tpg_engine.sv
// Block state, configuration registers and result register.
`timescale 1ns / 1ps
module tpg_engine
    import tpg_pkg::*;
#(
    parameter int CYCLE_BITS = CYCLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  t_item                 i_item,
    input  logic [CYCLE_BITS-1:0] i_cycle,
    output logic                  o_take,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  logic                  i_res_ready
);
    logic [LEN_W-1:0] r_pilot_len, r_sync1_len, r_sync2_len, r_zero_len, r_one_len;
    logic [GAP_W-1:0] r_gap_len;
    logic [LEN_W-1:0] r_hdr_pilot, r_data_pilot;

    t_phase                r_phase, n_phase;
    logic [CYCLE_BITS-1:0] r_edge_time, n_edge_time;
    logic [LEN_W-1:0]      r_pilot_edges, n_pilot_edges;
    logic                  r_half_toggle, n_half_toggle;
    logic [7:0]            r_bit_mask, n_bit_mask;
    logic [7:0]            r_cur_byte, n_cur_byte;
    logic [7:0]            r_la_byte, n_la_byte;
    logic                  r_la_valid, n_la_valid;
    logic [LEN_W-1:0]      r_bytes_played, n_bytes_played;
    logic [LEN_W-1:0]      r_size, n_size;
    logic                  r_long_pilot, n_long_pilot;
    logic [LEN_W-1:0]      r_half_len, n_half_len;
    logic                  r_ear, n_ear;
    logic                  r_paused, n_paused;
    logic                  n_req, n_urun;

    logic                  r_res_valid;
    t_result               r_res;

    logic [CYCLE_BITS-1:0] elapsed;
    logic [LEN_W-1:0]      pilot_limit;
    logic [LEN_W:0]        pilot_next;
    logic                  fire;

    assign o_take      = !r_res_valid || i_res_ready;
    assign fire        = i_valid && o_take;
    assign elapsed     = i_cycle - r_edge_time;
    assign pilot_limit = r_long_pilot ? r_hdr_pilot : r_data_pilot;
    assign pilot_next  = {1'b0, r_pilot_edges} + {{LEN_W{1'b0}}, 1'b1};

    always_comb begin
        n_phase        = r_phase;
        n_edge_time    = r_edge_time;
        n_pilot_edges  = r_pilot_edges;
        n_half_toggle  = r_half_toggle;
        n_bit_mask     = r_bit_mask;
        n_cur_byte     = r_cur_byte;
        n_la_byte      = r_la_byte;
        n_la_valid     = r_la_valid;
        n_bytes_played = r_bytes_played;
        n_size         = r_size;
        n_long_pilot   = r_long_pilot;
        n_half_len     = r_half_len;
        n_ear          = r_ear;
        n_paused       = r_paused;
        n_req          = 1'b0;
        n_urun         = 1'b0;
        case (t_cmd'(i_item.command))
            CMD_SAMPLE: begin
                if (r_phase != PH_IDLE && !r_paused) begin
                    case (r_phase)
                        PH_PILOT: begin
                            if (elapsed > CYCLE_BITS'(r_pilot_len)) begin
                                n_edge_time = i_cycle;
                                n_ear       = ~r_ear;
                                if (pilot_next > {1'b0, pilot_limit}) begin
                                    n_pilot_edges = '0;
                                    n_phase       = PH_SYNC1;
                                end else begin
                                    n_pilot_edges = pilot_next[LEN_W-1:0];
                                end
                            end
                        end
                        PH_SYNC1: begin
                            if (elapsed > CYCLE_BITS'(r_sync1_len)) begin
                                n_edge_time = i_cycle;
                                n_ear       = ~r_ear;
                                n_phase     = PH_SYNC2;
                            end
                        end
                        PH_SYNC2: begin
                            if (elapsed > CYCLE_BITS'(r_sync2_len)) begin
                                n_edge_time = i_cycle;
                                n_ear       = ~r_ear;
                                n_half_len  = ((r_cur_byte & r_bit_mask) != 8'd0) ?
                                              r_one_len : r_zero_len;
                                n_phase     = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            if (elapsed > CYCLE_BITS'(r_half_len)) begin
                                n_edge_time   = i_cycle;
                                n_ear         = ~r_ear;
                                n_half_toggle = ~r_half_toggle;
                                if (r_half_toggle) begin
                                    n_bit_mask = {r_bit_mask[0], r_bit_mask[7:1]};
                                    if (r_bit_mask[0]) begin
                                        n_bytes_played = r_bytes_played + LEN_W'(1);
                                        if (n_bytes_played == r_size) begin
                                            n_phase = PH_GAP;
                                            n_ear   = 1'b0;
                                        end else begin
                                            if (r_la_valid) begin
                                                n_cur_byte = r_la_byte;
                                                n_la_valid = 1'b0;
                                            end else begin
                                                n_cur_byte = 8'd0;
                                                n_urun     = 1'b1;
                                            end
                                            n_half_len = ((n_cur_byte & n_bit_mask) != 8'd0) ?
                                                         r_one_len : r_zero_len;
                                        end
                                    end else begin
                                        n_half_len = ((r_cur_byte & n_bit_mask) != 8'd0) ?
                                                     r_one_len : r_zero_len;
                                    end
                                end
                            end
                        end
                        PH_GAP: begin
                            if (elapsed > CYCLE_BITS'(r_gap_len)) begin
                                n_req   = 1'b1;
                                n_phase = PH_IDLE;
                                n_ear   = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_START: begin
                n_size         = i_item.block_size;
                n_long_pilot   = i_item.header_block;
                n_cur_byte     = i_item.data_byte;
                n_la_valid     = 1'b0;
                n_la_byte      = 8'd0;
                n_bytes_played = '0;
                n_pilot_edges  = '0;
                n_half_toggle  = 1'b0;
                n_bit_mask     = BIT_MASK_INIT;
                n_half_len     = r_zero_len;
                n_ear          = 1'b0;
                n_paused       = 1'b0;
                n_edge_time    = i_cycle;
                n_phase        = PH_PILOT;
            end
            CMD_SUPPLY: begin
                n_la_byte  = i_item.data_byte;
                n_la_valid = 1'b1;
            end
            CMD_TOGGLE: begin
                if (r_phase != PH_IDLE) begin
                    if (r_paused) begin
                        n_paused    = 1'b0;
                        n_edge_time = i_cycle;
                    end else begin
                        n_paused = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pilot_len    <= PILOT_LEN_RST;
            r_sync1_len    <= SYNC1_LEN_RST;
            r_sync2_len    <= SYNC2_LEN_RST;
            r_zero_len     <= ZERO_LEN_RST;
            r_one_len      <= ONE_LEN_RST;
            r_gap_len      <= GAP_LEN_RST;
            r_hdr_pilot    <= HDR_PILOT_RST;
            r_data_pilot   <= DATA_PILOT_RST;
            r_phase        <= PH_IDLE;
            r_edge_time    <= '0;
            r_pilot_edges  <= '0;
            r_half_toggle  <= 1'b0;
            r_bit_mask     <= BIT_MASK_INIT;
            r_cur_byte     <= 8'd0;
            r_la_byte      <= 8'd0;
            r_la_valid     <= 1'b0;
            r_bytes_played <= '0;
            r_size         <= '0;
            r_long_pilot   <= 1'b1;
            r_half_len     <= ZERO_LEN_RST;
            r_ear          <= 1'b0;
            r_paused       <= 1'b0;
            r_res_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PILOT_LEN:  r_pilot_len  <= i_cfg_data[LEN_W-1:0];
                    CFG_SYNC1_LEN:  r_sync1_len  <= i_cfg_data[LEN_W-1:0];
                    CFG_SYNC2_LEN:  r_sync2_len  <= i_cfg_data[LEN_W-1:0];
                    CFG_ZERO_LEN:   r_zero_len   <= i_cfg_data[LEN_W-1:0];
                    CFG_ONE_LEN:    r_one_len    <= i_cfg_data[LEN_W-1:0];
                    CFG_GAP_LEN:    r_gap_len    <= i_cfg_data[GAP_W-1:0];
                    CFG_HDR_PILOT:  r_hdr_pilot  <= i_cfg_data[LEN_W-1:0];
                    CFG_DATA_PILOT: r_data_pilot <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (fire) begin
                r_phase        <= n_phase;
                r_edge_time    <= n_edge_time;
                r_pilot_edges  <= n_pilot_edges;
                r_half_toggle  <= n_half_toggle;
                r_bit_mask     <= n_bit_mask;
                r_cur_byte     <= n_cur_byte;
                r_la_byte      <= n_la_byte;
                r_la_valid     <= n_la_valid;
                r_bytes_played <= n_bytes_played;
                r_size         <= n_size;
                r_long_pilot   <= n_long_pilot;
                r_half_len     <= n_half_len;
                r_ear          <= n_ear;
                r_paused       <= n_paused;
                r_res_valid    <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
        if (fire) begin
            r_res.ear_bit       <= n_ear;
            r_res.phase         <= n_phase;
            r_res.need_byte     <= ~n_la_valid;
            r_res.request_block <= n_req;
            r_res.underrun      <= n_urun;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
endmodule

### rtl/tpg_checker.sv
// Port-level checker for the tape pulse generator, bound to the top level.
`timescale 1ns / 1ps
`include "tape_pulse_generator_assert.svh"
module tpg_checker
    import tpg_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_ear_bit,
    input logic [2:0] i_phase,
    input logic       i_request_block,
    input logic       i_underrun
);
    // stalled result holds
    `TPG_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_phase) && $stable(i_ear_bit), "result changed while stalled")
    // gap end lands in idle with the line low
    `TPG_ASSERT_IMP(a_req_idle, i_clk, i_rst_n, i_res_valid && i_request_block, i_phase == PH_IDLE && !i_ear_bit, "block request outside idle")
    // underrun only while playing data
    `TPG_ASSERT_IMP(a_urun_data, i_clk, i_rst_n, i_res_valid && i_underrun, i_phase == PH_DATA, "underrun outside data phase")
    // no result right after reset
    `TPG_ASSERT_NXT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n, !i_res_valid, "result valid after reset")
endmodule

bind tape_pulse_generator tpg_checker u_tpg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res_chan.valid),
    .i_res_ready     (o_res_chan.ready),
    .i_ear_bit       (o_res_chan.ear_bit),
    .i_phase         (o_res_chan.phase),
    .i_request_block (o_res_chan.request_block),
    .i_underrun      (o_res_chan.underrun)
);

### sim/tpg_pulse_checker.sv
// Checker: follows the tape pulse generator's traffic, predicts each result and compares it.
`timescale 1ns / 1ps
module tpg_pulse_checker
    import tpg_pkg::*;
#(
    parameter int CYCLE_BITS = CYCLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tpg_in_if                     i_cmd_mon,
    tpg_out_if                    i_res_mon,
    output int                    o_pending,
    output int                    o_mismatches
);

    logic [LEN_W-1:0]      pilot_len, sync1_len, sync2_len, zero_len, one_len;
    logic [GAP_W-1:0]      gap_len;
    logic [LEN_W-1:0]      hdr_pilot_cnt, data_pilot_cnt;

    t_phase                tape_phase;
    logic [CYCLE_BITS-1:0] last_edge;
    logic [LEN_W-1:0]      pilot_edges;
    logic                  second_half;
    logic [7:0]            bit_mask, cur_byte, ahead_byte;
    logic                  ahead_full;
    logic [LEN_W-1:0]      bytes_played, block_len;
    logic                  long_pilot;
    logic [LEN_W-1:0]      half_len;
    logic                  ear, paused;

    t_result               expected_levels[$];
    int                    mismatches = 0;

    function automatic void reset_tape();
        pilot_len      = PILOT_LEN_RST;
        sync1_len      = SYNC1_LEN_RST;
        sync2_len      = SYNC2_LEN_RST;
        zero_len       = ZERO_LEN_RST;
        one_len        = ONE_LEN_RST;
        gap_len        = GAP_LEN_RST;
        hdr_pilot_cnt  = HDR_PILOT_RST;
        data_pilot_cnt = DATA_PILOT_RST;
        tape_phase     = PH_IDLE;
        last_edge      = '0;
        pilot_edges    = '0;
        second_half    = 1'b0;
        bit_mask       = BIT_MASK_INIT;
        cur_byte       = '0;
        ahead_byte     = '0;
        ahead_full     = 1'b0;
        bytes_played   = '0;
        block_len      = '0;
        long_pilot     = 1'b1;
        half_len       = ZERO_LEN_RST;
        ear            = 1'b0;
        paused         = 1'b0;
    endfunction

    function automatic void write_timing(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        case (t_cfg_idx'(idx))
            CFG_PILOT_LEN:  pilot_len      = data[LEN_W-1:0];
            CFG_SYNC1_LEN:  sync1_len      = data[LEN_W-1:0];
            CFG_SYNC2_LEN:  sync2_len      = data[LEN_W-1:0];
            CFG_ZERO_LEN:   zero_len       = data[LEN_W-1:0];
            CFG_ONE_LEN:    one_len        = data[LEN_W-1:0];
            CFG_GAP_LEN:    gap_len        = data[GAP_W-1:0];
            CFG_HDR_PILOT:  hdr_pilot_cnt  = data[LEN_W-1:0];
            CFG_DATA_PILOT: data_pilot_cnt = data[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void pick_half_len();
        half_len = ((cur_byte & bit_mask) != 0) ? one_len : zero_len;
    endfunction

    // One sample: at most one edge, fired once the elapsed cycles exceed the current length.
    function automatic void advance_tape(input logic [CYCLE_BITS-1:0] now,
                                         output logic req, output logic urun);
        logic [CYCLE_BITS-1:0] elapsed;
        logic [LEN_W-1:0]      limit;
        logic [LEN_W:0]        next_cnt;
        req     = 1'b0;
        urun    = 1'b0;
        elapsed = now - last_edge;
        case (tape_phase)
            PH_PILOT: if (elapsed > pilot_len) begin
                last_edge = now;
                ear       = ~ear;
                limit     = long_pilot ? hdr_pilot_cnt : data_pilot_cnt;
                next_cnt  = {1'b0, pilot_edges} + (LEN_W+1)'(1);
                if (next_cnt > {1'b0, limit}) begin
                    pilot_edges = '0;
                    tape_phase  = PH_SYNC1;
                end else begin
                    pilot_edges = next_cnt[LEN_W-1:0];
                end
            end
            PH_SYNC1: if (elapsed > sync1_len) begin
                last_edge  = now;
                ear        = ~ear;
                tape_phase = PH_SYNC2;
            end
            PH_SYNC2: if (elapsed > sync2_len) begin
                last_edge  = now;
                ear        = ~ear;
                pick_half_len();
                tape_phase = PH_DATA;
            end
            PH_DATA: if (elapsed > half_len) begin
                last_edge   = now;
                ear         = ~ear;
                second_half = ~second_half;
                if (!second_half) begin
                    bit_mask = {bit_mask[0], bit_mask[7:1]};
                    if (bit_mask == BIT_MASK_INIT) begin
                        bytes_played = bytes_played + LEN_W'(1);
                        if (bytes_played == block_len) begin
                            tape_phase = PH_GAP;
                            ear        = 1'b0;
                            return;
                        end
                        if (ahead_full) begin
                            cur_byte   = ahead_byte;
                            ahead_full = 1'b0;
                        end else begin
                            cur_byte = '0;
                            urun     = 1'b1;
                        end
                    end
                    pick_half_len();
                end
            end
            PH_GAP: if (elapsed > gap_len) begin
                req        = 1'b1;
                tape_phase = PH_IDLE;
                ear        = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic t_result tape_step(logic [1:0] cmd_bits, logic [CYCLE_BITS-1:0] now,
                                          logic [LEN_W-1:0] size_in, logic hdr,
                                          logic [7:0] dbyte);
        t_result res;
        logic    req, urun;
        req  = 1'b0;
        urun = 1'b0;
        case (t_cmd'(cmd_bits))
            CMD_SAMPLE: if (tape_phase != PH_IDLE && !paused) advance_tape(now, req, urun);
            CMD_START: begin
                block_len    = size_in;
                long_pilot   = hdr;
                cur_byte     = dbyte;
                ahead_full   = 1'b0;
                ahead_byte   = '0;
                bytes_played = '0;
                pilot_edges  = '0;
                second_half  = 1'b0;
                bit_mask     = BIT_MASK_INIT;
                half_len     = zero_len;
                ear          = 1'b0;
                paused       = 1'b0;
                last_edge    = now;
                tape_phase   = PH_PILOT;
            end
            CMD_SUPPLY: begin
                ahead_byte = dbyte;
                ahead_full = 1'b1;
            end
            CMD_TOGGLE: if (tape_phase != PH_IDLE) begin
                if (paused) begin
                    paused    = 1'b0;
                    last_edge = now;
                end else begin
                    paused = 1'b1;
                end
            end
            default: ;
        endcase
        res.ear_bit       = ear;
        res.phase         = tape_phase;
        res.need_byte     = !ahead_full;
        res.request_block = req;
        res.underrun      = urun;
        return res;
    endfunction

    function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got, want;
        if (!i_rst_n) begin
            reset_tape();
            expected_levels.delete();
        end else begin
            if (i_res_mon.valid && i_res_mon.ready) begin
                got.ear_bit       = i_res_mon.ear_bit;
                got.phase         = i_res_mon.phase;
                got.need_byte     = i_res_mon.need_byte;
                got.request_block = i_res_mon.request_block;
                got.underrun      = i_res_mon.underrun;
                if (expected_levels.size() == 0) begin
                    $error("result transaction with nothing expected: %p", got);
                    mismatches++;
                end else begin
                    want = expected_levels.pop_front();
                    check_field("ear_bit", 3'(want.ear_bit), 3'(got.ear_bit));
                    check_field("phase", want.phase, got.phase);
                    check_field("need_byte", 3'(want.need_byte), 3'(got.need_byte));
                    check_field("request_block", 3'(want.request_block),
                                3'(got.request_block));
                    check_field("underrun", 3'(want.underrun), 3'(got.underrun));
                end
            end
            if (i_cfg_we) write_timing(i_cfg_idx, i_cfg_data);
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                expected_levels.push_back(tape_step(i_cmd_mon.command, i_cmd_mon.cycle_now,
                                                    i_cmd_mon.block_size,
                                                    i_cmd_mon.header_block,
                                                    i_cmd_mon.data_byte));
            end
        end
        o_pending    <= expected_levels.size();
        o_mismatches <= mismatches;
    end

endmodule

### sim/testbench.sv
// Testbench top: drives tape commands and timing writes into the tape pulse generator.
`timescale 1ns / 1ps
module testbench;
    import tpg_pkg::*;

    localparam int CB        = CYCLE_BITS_DEF;
    localparam int RUN_LIMIT = 500_000;
    localparam int BLOCK_CAP = 700;

    typedef enum {TIMING_MIN, TIMING_MAX, TIMING_SHORT} t_timing;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tpg_in_if #(.CYCLE_BITS(CB)) cmd_if ();
    tpg_out_if                   res_if ();

    int            pending, mismatches;
    int            cycle_count    = 0;
    int            blocks_done    = 0;
    int            blocks_seen    = 0;
    int            items_in_block = 0;
    int            step_span      = 4;
    int            sink_hold      = 0;
    logic          last_need      = 1'b1;
    logic          starving       = 1'b0;
    logic          pause_guess    = 1'b0;
    logic          sender_calm    = 1'b0;
    logic          sink_calm      = 1'b0;
    logic [CB-1:0] tape_now       = '0;

    tape_pulse_generator #(.CYCLE_BITS(CB)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd_chan (cmd_if),
        .o_res_chan (res_if)
    );

    tpg_pulse_checker #(.CYCLE_BITS(CB)) pulse_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_cmd_mon    (cmd_if),
        .i_res_mon    (res_if),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("** tape_pulse_generator: FAILED **");
            $finish;
        end
    end

    // Result sink: random stall after each transaction, with calm stretches.
    always @(posedge i_clk) begin : res_sink
        int stall;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            sink_hold    <= 0;
        end else if (res_if.ready) begin
            if (res_if.valid) begin
                if ($urandom_range(0, 79) == 0) sink_calm = !sink_calm;
                stall = sink_calm ? 0 : $urandom_range(0, 17);
                if (stall != 0) begin
                    res_if.ready <= 1'b0;
                    sink_hold    <= stall;
                end
                if (res_if.request_block) blocks_done <= blocks_done + 1;
                last_need <= res_if.need_byte;
            end
        end else if (sink_hold > 1) begin
            sink_hold <= sink_hold - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [CB-1:0] now,
                             input logic [LEN_W-1:0] size_in, input logic hdr,
                             input logic [7:0] dbyte);
        int idle_cycles;
        idle_cycles = sender_calm ? 0 : $urandom_range(0, 17);
        if (idle_cycles != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (idle_cycles) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.command      <= cmd;
        cmd_if.cycle_now    <= now;
        cmd_if.block_size   <= size_in;
        cmd_if.header_block <= hdr;
        cmd_if.data_byte    <= dbyte;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_timing(input t_timing mode);
        logic [CFG_DATA_W-1:0] timing [8];
        int                    widest;
        for (int i = CFG_PILOT_LEN; i <= CFG_DATA_PILOT; i++) begin
            case (mode)
                TIMING_MIN: timing[i] = CFG_DATA_W'((i <= CFG_ONE_LEN) ? 1 : 0);
                TIMING_MAX: timing[i] = (i == CFG_GAP_LEN) ? {GAP_W{1'b1}} : {LEN_W{1'b1}};
                default:    timing[i] = CFG_DATA_W'((i <= CFG_ONE_LEN) ? $urandom_range(1, 12) :
                                                    (i == CFG_GAP_LEN) ? $urandom_range(0, 40) :
                                                                         $urandom_range(0, 10));
            endcase
        end
        widest = 0;
        for (int i = CFG_PILOT_LEN; i <= CFG_ONE_LEN; i++)
            if (timing[i] > widest) widest = timing[i];
        step_span = 2 * widest + 2;
        for (int i = CFG_PILOT_LEN; i <= CFG_DATA_PILOT; i++) begin
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= timing[i];
            cfg_we   <= 1'b1;
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic void advance_now();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)
            tape_now = tape_now + $urandom_range(0, step_span);
        else if (r < 98)
            tape_now = tape_now + $urandom_range(0, 32'h1FF_FFFF);
        else
            tape_now = CB'({$urandom, $urandom});
    endfunction

    function automatic logic [LEN_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return LEN_W'($urandom_range(1, 4));
        if (r < 88) return LEN_W'($urandom_range(5, 40));
        if (r < 94) return '0;
        return LEN_W'($urandom);
    endfunction

    // Mostly whole blocks: start, samples, timely or late supplies, paired pause/resume.
    task automatic random_item();
        int pick, supply_odds;
        pick = $urandom_range(0, 999);
        supply_odds = !last_need ? 15 : starving ? 25 : 250;
        items_in_block++;
        if ($urandom_range(0, 59) == 0) sender_calm = !sender_calm;
        advance_now();
        if (blocks_done != blocks_seen || items_in_block > BLOCK_CAP || pick < 3) begin
            blocks_seen    = blocks_done;
            items_in_block = 0;
            starving       = ($urandom_range(0, 3) == 0);
            pause_guess    = 1'b0;
            send_item(CMD_START, tape_now, pick_size(), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
        end else if (pause_guess ? pick < 170 : pick < 8) begin
            pause_guess = !pause_guess;
            send_item(CMD_TOGGLE, tape_now, LEN_W'($urandom), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 999) < supply_odds) begin
            send_item(CMD_SUPPLY, tape_now, LEN_W'($urandom), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
        end else begin
            send_item(CMD_SAMPLE, tape_now, LEN_W'($urandom), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        cmd_if.valid        <= 1'b0;
        cmd_if.command      <= CMD_SAMPLE;
        cmd_if.cycle_now    <= '0;
        cmd_if.block_size   <= '0;
        cmd_if.header_block <= 1'b0;
        cmd_if.data_byte    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default timing: idle commands, lookahead overwrite, wrap of the cycle count,
        // the strict length boundary, pause and resume, restart with size zero.
        send_item(CMD_SAMPLE, '0, 16'h0000, 1'b0, 8'h00);
        send_item(CMD_TOGGLE, '1, 16'hFFFF, 1'b1, 8'hFF);
        send_item(CMD_SUPPLY, 48'h0000_0000_1000, 16'h1234, 1'b0, 8'hFF);
        send_item(CMD_SUPPLY, 48'h0000_0000_1001, 16'h0000, 1'b1, 8'h00);
        tape_now = 48'hFFFF_FFFF_FC00;
        send_item(CMD_START, tape_now, 16'hFFFF, 1'b1, 8'hFF);
        send_item(CMD_SAMPLE, tape_now + PILOT_LEN_RST, 16'h0000, 1'b0, 8'h00);
        tape_now = tape_now + PILOT_LEN_RST + 1;
        send_item(CMD_SAMPLE, tape_now, 16'h0000, 1'b0, 8'h00);
        send_item(CMD_TOGGLE, tape_now + 5, 16'h0000, 1'b0, 8'h00);
        tape_now = tape_now + 100_000;
        send_item(CMD_SAMPLE, tape_now, 16'h0000, 1'b0, 8'h00);
        send_item(CMD_TOGGLE, tape_now, 16'h0000, 1'b0, 8'h00);
        tape_now = tape_now + PILOT_LEN_RST + 1;
        send_item(CMD_SAMPLE, tape_now, 16'h0000, 1'b0, 8'h00);
        send_item(CMD_SUPPLY, tape_now, 16'h0000, 1'b0, 8'hA5);
        send_item(CMD_SUPPLY, tape_now, 16'h0000, 1'b0, 8'h5A);
        tape_now = '0;
        send_item(CMD_START, tape_now, 16'h0000, 1'b0, 8'h00);
        tape_now = tape_now + PILOT_LEN_RST + 1;
        send_item(CMD_SAMPLE, tape_now, 16'hFFFF, 1'b1, 8'hFF);
        send_item(CMD_TOGGLE, tape_now, 16'hFFFF, 1'b1, 8'hFF);

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            load_timing(ph == 0 ? TIMING_MIN : ph == 4 ? TIMING_MAX : TIMING_SHORT);
            sender_calm    = ($urandom_range(0, 3) == 0);
            blocks_seen    = blocks_done;
            items_in_block = BLOCK_CAP + 1;
            repeat (ph == 4 ? 80 : 135) random_item();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("** tape_pulse_generator: PASSED **");
        else
            $display("** tape_pulse_generator: FAILED **");
        $finish;
    end

endmodule
